// ----- hw/rtl/gtl_pkg.sv -----
`default_nettype none

package gtl_pkg;

    // Fixed point layout: angles and trig values are signed Q(F)
    localparam int F     = 30;
    localparam int ITERS = F + 2;
    localparam int CW    = 36;            // datapath width
    localparam int DW    = 36;            // divider operand width
    localparam int QW    = 33;            // quotient bits: 3 integer + F fraction

    localparam logic signed [CW-1:0] DEG7_RAD   = 36'sd2012227627;  // pi/1.8e9, Q60
    localparam logic signed [CW-1:0] PI_Q       = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q  = 36'sd1686629713;
    localparam logic signed [CW-1:0] INV_GAIN_Q = 36'sd652032874;
    localparam logic signed [CW-1:0] GAIN_Q     = 36'sd1768195363;
    localparam logic signed [CW-1:0] ONE_Q      = 36'sd1073741824;
    localparam logic signed [CW-1:0] OUT_LIMIT  = 36'sd2100000000;

    localparam logic signed [33:0] DL_SPAN = 34'sd3600000000;
    localparam logic signed [33:0] DL_HALF = 34'sd1800000000;

    typedef enum logic [0:0] {
        REG_REF_LAT = 1'b0,
        REG_REF_LON = 1'b1
    } reg_idx_t;

    // atan(2^-i) in Q(F), rounded
    function automatic logic signed [CW-1:0] atan_q(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 36'sd843314857;
            1:  r = 36'sd497837829;
            2:  r = 36'sd263043837;
            3:  r = 36'sd133525159;
            4:  r = 36'sd67021687;
            5:  r = 36'sd33543516;
            6:  r = 36'sd16775851;
            7:  r = 36'sd8388437;
            8:  r = 36'sd4194283;
            9:  r = 36'sd2097149;
            default:
            begin
                if (i < F)
                    r = 36'sd1 <<< (F - i);
                else
                    r = 36'sd1;
            end
        endcase
        return r;
    endfunction

    // round(a*b / 2^F), half away from zero
    function automatic logic signed [CW-1:0] mul_q(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic [CW-1:0]   ma;
        logic [CW-1:0]   mb;
        logic [2*CW-1:0] p;
        logic [CW-1:0]   r;
        ma = a[CW-1] ? (~a + 1'b1) : a;
        mb = b[CW-1] ? (~b + 1'b1) : b;
        p  = ma * mb;
        p  = p + ((2*CW)'(1) << (F - 1));
        r  = p[F +: CW];
        return (a[CW-1] ^ b[CW-1]) ? $signed(~r + 1'b1) : $signed(r);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gtl_fix_if.sv -----
`default_nettype none

interface gtl_fix_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] fix_latitude;
    logic signed [31:0] fix_longitude;

    modport source (output valid, fix_latitude, fix_longitude, input ready);
    modport sink   (input valid, fix_latitude, fix_longitude, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gtl_offset_if.sv -----
`default_nettype none

interface gtl_offset_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] north_cm;
    logic signed [31:0] east_cm;
    logic               clipped;

    modport source (output valid, north_cm, east_cm, clipped, input ready);
    modport sink   (input valid, north_cm, east_cm, clipped, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/geodetic_to_local_projection.sv -----
// Throughput: one item per cycle while the output is not stalled; every stage is a register,
// the CORDIC chains and the restoring dividers each spend one stage per iteration.
// A stalled output holds the whole pipeline; fix.ready is low only while it is stalled.
// Reset (rst_n low, async): pipeline emptied, reference point set to 0/0.
`default_nettype none

module geodetic_to_local_projection #(
    parameter int EARTH_RADIUS_M = 6371000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    gtl_fix_if.sink     fix,
    gtl_offset_if.source offset
);
    import gtl_pkg::*;

    localparam logic signed [CW-1:0] RADIUS_CM = CW'(64'(EARTH_RADIUS_M) * 64'd100);
    // P0..P2, rotation, P3/M1/M2/M3, vectoring, P7/P8, vectoring, P9,
    // divider, P10/P11/P12/output
    localparam int NSTAGE = 3 + ITERS + 4 + ITERS + 2 + ITERS + 1 + QW + 4;

    typedef struct packed {
        logic                 flip;
        logic signed [CW-1:0] th;
    } fold_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] a;
    } v1_side_t;

    typedef struct packed {
        logic [DW-1:0] um;
        logic [DW-1:0] ux;
        logic [DW-1:0] uy;
        logic          nneg;
        logic          eneg;
        logic          special;
        logic          apos;
        logic          z0sel;
    } v2_side_t;

    typedef struct packed {
        logic signed [CW-1:0] c;
        logic [DW-1:0]        um;
        logic [DW-1:0]        ux;
        logic [DW-1:0]        uy;
        logic                 nneg;
        logic                 eneg;
        logic                 special;
        logic                 apos;
    } dv_side_t;

    // fold an angle into [-pi/2, pi/2]; cosine flips sign when folded
    function automatic fold_t fold(input logic signed [CW-1:0] th);
        fold_t r;
        r.flip = 1'b0;
        r.th   = th;
        if (th > HALF_PI_Q)
        begin
            r.flip = 1'b1;
            r.th   = PI_Q - th;
        end
        else if (th < -HALF_PI_Q)
        begin
            r.flip = 1'b1;
            r.th   = -PI_Q - th;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Handshake and valid line. One global advance; bubbles ride along.
    // ---------------------------------------------------------------
    logic              adv;
    logic              in_fire;
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;

    assign adv       = !vld_reg[NSTAGE-1] || offset.ready;
    assign fix.ready = adv;
    assign in_fire   = fix.valid && adv;
    assign vld_next  = {vld_reg[NSTAGE-2:0], in_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ---------------------------------------------------------------
    // Reference point registers
    // ---------------------------------------------------------------
    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_REF_LAT: ref_lat_reg <= cfg_data[30:0];
                REG_REF_LON: ref_lon_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // P0: longitude difference wrapped into [-180, 180) degrees
    // ---------------------------------------------------------------
    logic signed [33:0] dl_diff;
    logic signed [33:0] dl_mod;
    logic signed [33:0] dl_next;
    logic signed [30:0] p0_lat_reg;
    logic signed [31:0] p0_dl_reg;

    always_comb
    begin
        dl_diff = 34'(fix.fix_longitude) - 34'(ref_lon_reg);
        if (dl_diff >= DL_SPAN)
            dl_mod = dl_diff - DL_SPAN;
        else if (dl_diff <= -DL_SPAN)
            dl_mod = dl_diff + DL_SPAN;
        else
            dl_mod = dl_diff;
        if (dl_mod >= DL_HALF)
            dl_next = dl_mod - DL_SPAN;
        else if (dl_mod < -DL_HALF)
            dl_next = dl_mod + DL_SPAN;
        else
            dl_next = dl_mod;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_lat_reg <= fix.fix_latitude;
            p0_dl_reg  <= dl_next[31:0];
        end
    end

    // ---------------------------------------------------------------
    // P1: degrees*1e7 to radians;  P2: fold for the rotation CORDIC
    // ---------------------------------------------------------------
    logic signed [CW-1:0] p1_thl_reg;
    logic signed [CW-1:0] p1_th0_reg;
    logic signed [CW-1:0] p1_thd_reg;
    fold_t                p2_l_reg;
    fold_t                p2_0_reg;
    fold_t                p2_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_thl_reg <= mul_q(CW'(p0_lat_reg), DEG7_RAD);
            p1_th0_reg <= mul_q(CW'(ref_lat_reg), DEG7_RAD);
            p1_thd_reg <= mul_q(CW'(p0_dl_reg), DEG7_RAD);
            p2_l_reg   <= fold(p1_thl_reg);
            p2_0_reg   <= fold(p1_th0_reg);
            p2_d_reg   <= fold(p1_thd_reg);
        end
    end

    // ---------------------------------------------------------------
    // Three sine/cosine chains: fix latitude, reference latitude, dlon
    // ---------------------------------------------------------------
    logic signed [CW-1:0] rl_x, rl_y, r0_x, r0_y, rd_x, rd_y;
    logic [2:0]           rot_flip_reg [ITERS];

    gtl_rot u_rot_lat (.clk(clk), .en(adv), .x_in(INV_GAIN_Q), .y_in('0),
                       .z_in(p2_l_reg.th), .x_out(rl_x), .y_out(rl_y));
    gtl_rot u_rot_ref (.clk(clk), .en(adv), .x_in(INV_GAIN_Q), .y_in('0),
                       .z_in(p2_0_reg.th), .x_out(r0_x), .y_out(r0_y));
    gtl_rot u_rot_dl  (.clk(clk), .en(adv), .x_in(INV_GAIN_Q), .y_in('0),
                       .z_in(p2_d_reg.th), .x_out(rd_x), .y_out(rd_y));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_flip_reg[0] <= {p2_l_reg.flip, p2_0_reg.flip, p2_d_reg.flip};
            for (int i = 1; i < ITERS; i++)
                rot_flip_reg[i] <= rot_flip_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // P3: unfold cosines. M1..M3: X, Y and clamped cos(c) = A
    // ---------------------------------------------------------------
    logic signed [CW-1:0] p3_sl_reg, p3_cl_reg, p3_s0_reg, p3_c0_reg;
    logic signed [CW-1:0] p3_sd_reg, p3_cd_reg;
    logic signed [CW-1:0] m1_ccd_reg, m1_c0sl_reg, m1_s0sl_reg, m1_y_reg;
    logic signed [CW-1:0] m1_s0_reg, m1_c0_reg;
    logic signed [CW-1:0] m2_s0ccd_reg, m2_c0ccd_reg, m2_c0sl_reg, m2_s0sl_reg;
    logic signed [CW-1:0] m2_y_reg;
    logic signed [CW-1:0] a_sum;
    logic signed [CW-1:0] x_diff;
    logic signed [CW-1:0] a_next;
    v1_side_t             m3_side_reg;
    logic signed [CW-1:0] m3_ax_reg, m3_ay_reg;

    always_comb
    begin
        x_diff = m2_c0sl_reg - m2_s0ccd_reg;
        a_sum  = m2_s0sl_reg + m2_c0ccd_reg;
        if (a_sum > ONE_Q)
            a_next = ONE_Q;
        else if (a_sum < -ONE_Q)
            a_next = -ONE_Q;
        else
            a_next = a_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_sl_reg <= rl_y;
            p3_cl_reg <= rot_flip_reg[ITERS-1][2] ? -rl_x : rl_x;
            p3_s0_reg <= r0_y;
            p3_c0_reg <= rot_flip_reg[ITERS-1][1] ? -r0_x : r0_x;
            p3_sd_reg <= rd_y;
            p3_cd_reg <= rot_flip_reg[ITERS-1][0] ? -rd_x : rd_x;

            m1_ccd_reg  <= mul_q(p3_cl_reg, p3_cd_reg);
            m1_c0sl_reg <= mul_q(p3_c0_reg, p3_sl_reg);
            m1_s0sl_reg <= mul_q(p3_s0_reg, p3_sl_reg);
            m1_y_reg    <= mul_q(p3_cl_reg, p3_sd_reg);
            m1_s0_reg   <= p3_s0_reg;
            m1_c0_reg   <= p3_c0_reg;

            m2_s0ccd_reg <= mul_q(m1_s0_reg, m1_ccd_reg);
            m2_c0ccd_reg <= mul_q(m1_c0_reg, m1_ccd_reg);
            m2_c0sl_reg  <= m1_c0sl_reg;
            m2_s0sl_reg  <= m1_s0sl_reg;
            m2_y_reg     <= m1_y_reg;

            m3_side_reg.x <= x_diff;
            m3_side_reg.y <= m2_y_reg;
            m3_side_reg.a <= a_next;
            // mirror into the right half-plane for the vectoring CORDIC
            m3_ax_reg <= x_diff[CW-1] ? -x_diff : x_diff;
            m3_ay_reg <= x_diff[CW-1] ? -m2_y_reg : m2_y_reg;
        end
    end

    // ---------------------------------------------------------------
    // First vectoring chain: m = gain * sin(c)
    // ---------------------------------------------------------------
    logic signed [CW-1:0] v1_m;
    v1_side_t             v1_side_reg [ITERS];

    gtl_vec u_vec_mag (.clk(clk), .en(adv), .x_in(m3_ax_reg), .y_in(m3_ay_reg),
                       .x_out(v1_m), .z_out());

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_side_reg[0] <= m3_side_reg;
            for (int i = 1; i < ITERS; i++)
                v1_side_reg[i] <= v1_side_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // P7: gain-scaled A, X, Y.  P8: set up atan2(m, A) in the right half
    // ---------------------------------------------------------------
    logic signed [CW-1:0] p7_m_reg, p7_ag_reg, p7_xg_reg, p7_yg_reg;
    logic                 p7_apos_reg;
    logic signed [CW-1:0] p8_x_reg, p8_y_reg;
    v2_side_t             p8_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_m_reg    <= v1_m;
            p7_ag_reg   <= mul_q(v1_side_reg[ITERS-1].a, GAIN_Q);
            p7_xg_reg   <= mul_q(v1_side_reg[ITERS-1].x, GAIN_Q);
            p7_yg_reg   <= mul_q(v1_side_reg[ITERS-1].y, GAIN_Q);
            p7_apos_reg <= (v1_side_reg[ITERS-1].a > 0);

            if (p7_ag_reg[CW-1])
            begin
                p8_x_reg <= p7_m_reg;
                p8_y_reg <= -p7_ag_reg;
            end
            else
            begin
                p8_x_reg <= p7_ag_reg;
                p8_y_reg <= p7_m_reg;
            end
            p8_side_reg.z0sel   <= p7_ag_reg[CW-1];
            p8_side_reg.um      <= p7_m_reg;
            p8_side_reg.ux      <= p7_xg_reg[CW-1] ? -p7_xg_reg : p7_xg_reg;
            p8_side_reg.uy      <= p7_yg_reg[CW-1] ? -p7_yg_reg : p7_yg_reg;
            p8_side_reg.nneg    <= p7_xg_reg[CW-1];
            p8_side_reg.eneg    <= p7_yg_reg[CW-1];
            p8_side_reg.special <= (p7_m_reg <= 0);
            p8_side_reg.apos    <= p7_apos_reg;
        end
    end

    // ---------------------------------------------------------------
    // Second vectoring chain: central angle c.  P9: offset and clamp
    // ---------------------------------------------------------------
    logic signed [CW-1:0] v2_z;
    v2_side_t             v2_side_reg [ITERS];
    logic signed [CW-1:0] c_sum;
    logic signed [CW-1:0] c_next;
    dv_side_t             p9_side_reg;

    gtl_vec u_vec_ang (.clk(clk), .en(adv), .x_in(p8_x_reg), .y_in(p8_y_reg),
                       .x_out(), .z_out(v2_z));

    always_comb
    begin
        c_sum = v2_z + (v2_side_reg[ITERS-1].z0sel ? HALF_PI_Q : '0);
        if (c_sum[CW-1])
            c_next = '0;
        else if (c_sum > PI_Q)
            c_next = PI_Q;
        else
            c_next = c_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v2_side_reg[0] <= p8_side_reg;
            for (int i = 1; i < ITERS; i++)
                v2_side_reg[i] <= v2_side_reg[i-1];

            p9_side_reg.c       <= c_next;
            p9_side_reg.um      <= v2_side_reg[ITERS-1].um;
            p9_side_reg.ux      <= v2_side_reg[ITERS-1].ux;
            p9_side_reg.uy      <= v2_side_reg[ITERS-1].uy;
            p9_side_reg.nneg    <= v2_side_reg[ITERS-1].nneg;
            p9_side_reg.eneg    <= v2_side_reg[ITERS-1].eneg;
            p9_side_reg.special <= v2_side_reg[ITERS-1].special;
            p9_side_reg.apos    <= v2_side_reg[ITERS-1].apos;
        end
    end

    // ---------------------------------------------------------------
    // Two restoring dividers (north on |X g|, east on |Y g|), one quotient bit per stage:
    // q = floor(|X g| * 2^F / m), plus the final remainder
    // ---------------------------------------------------------------
    logic [DW-1:0] nrem_reg [QW];
    logic [DW-1:0] erem_reg [QW];
    logic [QW-1:0] nq_reg [QW];
    logic [QW-1:0] eq_reg [QW];
    logic [DW-1:0] nrem_next [QW];
    logic [DW-1:0] erem_next [QW];
    logic [QW-1:0] nq_next [QW];
    logic [QW-1:0] eq_next [QW];
    dv_side_t      dv_side_reg [QW];

    always_comb
    begin
        dv_side_t      s;
        logic [DW-1:0] rn;
        logic [DW-1:0] re;
        logic [QW-1:0] qn;
        logic [QW-1:0] qe;
        logic [DW:0]   tn;
        logic [DW:0]   te;
        logic          bn;
        logic          be;
        int            p;
        for (int k = 0; k < QW; k++)
        begin
            p = QW - 1 - k;
            if (k == 0)
            begin
                s  = p9_side_reg;
                rn = p9_side_reg.ux >> (QW - F);
                re = p9_side_reg.uy >> (QW - F);
                qn = '0;
                qe = '0;
            end
            else
            begin
                s  = dv_side_reg[(k == 0) ? 0 : k - 1];
                rn = nrem_reg[(k == 0) ? 0 : k - 1];
                re = erem_reg[(k == 0) ? 0 : k - 1];
                qn = nq_reg[(k == 0) ? 0 : k - 1];
                qe = eq_reg[(k == 0) ? 0 : k - 1];
            end
            bn = (p >= F) ? s.ux[(p >= F) ? p - F : 0] : 1'b0;
            be = (p >= F) ? s.uy[(p >= F) ? p - F : 0] : 1'b0;
            tn = {rn, bn};
            te = {re, be};
            if (tn >= {1'b0, s.um})
            begin
                nrem_next[k] = DW'(tn - {1'b0, s.um});
                nq_next[k]   = {qn[QW-2:0], 1'b1};
            end
            else
            begin
                nrem_next[k] = tn[DW-1:0];
                nq_next[k]   = {qn[QW-2:0], 1'b0};
            end
            if (te >= {1'b0, s.um})
            begin
                erem_next[k] = DW'(te - {1'b0, s.um});
                eq_next[k]   = {qe[QW-2:0], 1'b1};
            end
            else
            begin
                erem_next[k] = te[DW-1:0];
                eq_next[k]   = {qe[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nrem_reg       <= nrem_next;
            erem_reg       <= erem_next;
            nq_reg         <= nq_next;
            eq_reg         <= eq_next;
            dv_side_reg[0] <= p9_side_reg;
            for (int k = 1; k < QW; k++)
                dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // P10: round quotient half up.  P11: c*q.  P12: scale to cm, sign.
    // ---------------------------------------------------------------
    dv_side_t             last_side;
    logic [QW:0]          qn_rnd;
    logic [QW:0]          qe_rnd;
    logic [QW:0]          p10_qn_reg, p10_qe_reg;
    dv_side_t             p10_side_reg;
    logic signed [CW-1:0] p11_crn_reg, p11_cre_reg;
    dv_side_t             p11_side_reg;
    logic signed [CW-1:0] dn_mag;
    logic signed [CW-1:0] de_mag;
    logic signed [CW-1:0] p12_dn_reg, p12_de_reg;
    logic                 p12_special_reg, p12_apos_reg;

    assign last_side = dv_side_reg[QW-1];
    assign qn_rnd = (QW+1)'(nq_reg[QW-1])
                  + (QW+1)'({nrem_reg[QW-1], 1'b0} >= {1'b0, last_side.um});
    assign qe_rnd = (QW+1)'(eq_reg[QW-1])
                  + (QW+1)'({erem_reg[QW-1], 1'b0} >= {1'b0, last_side.um});
    assign dn_mag = mul_q(p11_crn_reg, RADIUS_CM);
    assign de_mag = mul_q(p11_cre_reg, RADIUS_CM);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_qn_reg   <= qn_rnd;
            p10_qe_reg   <= qe_rnd;
            p10_side_reg <= last_side;

            p11_crn_reg  <= mul_q(p10_side_reg.c, $signed(CW'(p10_qn_reg)));
            p11_cre_reg  <= mul_q(p10_side_reg.c, $signed(CW'(p10_qe_reg)));
            p11_side_reg <= p10_side_reg;

            p12_dn_reg      <= p11_side_reg.nneg ? -dn_mag : dn_mag;
            p12_de_reg      <= p11_side_reg.eneg ? -de_mag : de_mag;
            p12_special_reg <= p11_side_reg.special;
            p12_apos_reg    <= p11_side_reg.apos;
        end
    end

    // ---------------------------------------------------------------
    // Output register: coincident / antipode cases, then saturation
    // ---------------------------------------------------------------
    logic signed [CW-1:0] north_sat, east_sat;
    logic                 north_clip, east_clip;
    logic signed [31:0]   north_next, east_next;
    logic                 clip_next;
    logic signed [31:0]   north_reg, east_reg;
    logic                 clip_reg;

    always_comb
    begin
        north_clip = 1'b1;
        east_clip  = 1'b1;
        if (p12_dn_reg > OUT_LIMIT)
            north_sat = OUT_LIMIT;
        else if (p12_dn_reg < -OUT_LIMIT)
            north_sat = -OUT_LIMIT;
        else
        begin
            north_sat  = p12_dn_reg;
            north_clip = 1'b0;
        end
        if (p12_de_reg > OUT_LIMIT)
            east_sat = OUT_LIMIT;
        else if (p12_de_reg < -OUT_LIMIT)
            east_sat = -OUT_LIMIT;
        else
        begin
            east_sat  = p12_de_reg;
            east_clip = 1'b0;
        end

        if (p12_special_reg && p12_apos_reg)
        begin
            // coincident point
            north_next = '0;
            east_next  = '0;
            clip_next  = 1'b0;
        end
        else if (p12_special_reg)
        begin
            // antipode: direction undefined, report due north at the limit
            north_next = OUT_LIMIT[31:0];
            east_next  = '0;
            clip_next  = 1'b1;
        end
        else
        begin
            north_next = north_sat[31:0];
            east_next  = east_sat[31:0];
            clip_next  = north_clip || east_clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            north_reg <= north_next;
            east_reg  <= east_next;
            clip_reg  <= clip_next;
        end
    end

    assign offset.valid    = vld_reg[NSTAGE-1];
    assign offset.north_cm = north_reg;
    assign offset.east_cm  = east_reg;
    assign offset.clipped  = clip_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gtl_rot.sv -----
`default_nettype none

// Rotation CORDIC, one iteration per register stage
module gtl_rot (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [gtl_pkg::CW-1:0] x_in,
    input  logic signed [gtl_pkg::CW-1:0] y_in,
    input  logic signed [gtl_pkg::CW-1:0] z_in,
    output logic signed [gtl_pkg::CW-1:0] x_out,
    output logic signed [gtl_pkg::CW-1:0] y_out
);
    import gtl_pkg::*;

    logic signed [CW-1:0] x_reg [ITERS];
    logic signed [CW-1:0] y_reg [ITERS];
    logic signed [CW-1:0] z_reg [ITERS];
    logic signed [CW-1:0] x_next [ITERS];
    logic signed [CW-1:0] y_next [ITERS];
    logic signed [CW-1:0] z_next [ITERS];

    always_comb
    begin
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        for (int i = 0; i < ITERS; i++)
        begin
            xi = (i == 0) ? x_in : x_reg[(i == 0) ? 0 : i - 1];
            yi = (i == 0) ? y_in : y_reg[(i == 0) ? 0 : i - 1];
            zi = (i == 0) ? z_in : z_reg[(i == 0) ? 0 : i - 1];
            if (!zi[CW-1])
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - atan_q(i);
            end
            else
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + atan_q(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg[ITERS-1];
    assign y_out = y_reg[ITERS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/gtl_vec.sv -----
`default_nettype none

// Vectoring CORDIC, one iteration per register stage; x_out = gain * hypot
module gtl_vec (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [gtl_pkg::CW-1:0] x_in,
    input  logic signed [gtl_pkg::CW-1:0] y_in,
    output logic signed [gtl_pkg::CW-1:0] x_out,
    output logic signed [gtl_pkg::CW-1:0] z_out
);
    import gtl_pkg::*;

    logic signed [CW-1:0] x_reg [ITERS];
    logic signed [CW-1:0] y_reg [ITERS];
    logic signed [CW-1:0] z_reg [ITERS];
    logic signed [CW-1:0] x_next [ITERS];
    logic signed [CW-1:0] y_next [ITERS];
    logic signed [CW-1:0] z_next [ITERS];

    always_comb
    begin
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        for (int i = 0; i < ITERS; i++)
        begin
            xi = (i == 0) ? x_in : x_reg[(i == 0) ? 0 : i - 1];
            yi = (i == 0) ? y_in : y_reg[(i == 0) ? 0 : i - 1];
            zi = (i == 0) ? '0   : z_reg[(i == 0) ? 0 : i - 1];
            if (!yi[CW-1])
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + atan_q(i);
            end
            else
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - atan_q(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg[ITERS-1];
    assign z_out = z_reg[ITERS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/gtl_checker.sv -----
`default_nettype none

module gtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        fix_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] north_cm,
    input logic [31:0] east_cm,
    input logic        clipped
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(north_cm) && $stable(east_cm)
                                       && $stable(clipped)))
        else $error("offset item changed while stalled");

    // input only backs off while the output is blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !fix_ready |-> (out_valid && !out_ready))
        else $error("fix.ready low without output backpressure");

    // offsets never leave the saturation range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(north_cm) <= 32'sd2100000000
                       && $signed(north_cm) >= -32'sd2100000000
                       && $signed(east_cm) <= 32'sd2100000000
                       && $signed(east_cm) >= -32'sd2100000000))
        else $error("offset beyond saturation limit");

    // pipeline comes out of reset empty
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind geodetic_to_local_projection gtl_checker u_gtl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fix_ready (fix.ready),
    .out_valid (offset.valid),
    .out_ready (offset.ready),
    .north_cm  (offset.north_cm),
    .east_cm   (offset.east_cm),
    .clipped   (offset.clipped)
);

`default_nettype wire
